FILE: sv/v3a_pkg.sv
// v3a_pkg: shared types, opcodes and helper functions for the vector3 fixed-point ALU.
// No dependencies.
package v3a_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_STEPS    = 32;

    typedef enum logic [3:0] {
        FN_ADD   = 4'd0,
        FN_SUB   = 4'd1,
        FN_SCALE = 4'd2,
        FN_DOT   = 4'd3,
        FN_CROSS = 4'd4,
        FN_NORM2 = 4'd5,
        FN_NORM  = 4'd6,
        FN_NRMLZ = 4'd7,
        FN_EQ    = 4'd8
    } func_t;

    // register index as decoded from paddr[2]
    localparam logic REG_MIN_NORM_SQ = 1'b0;

    typedef struct packed {
        logic [3:0]  func;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] rs;
        logic        flag;
        logic        sat;
        logic [2:0]  neg;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic [31:0] mag_z;
        logic        norm_ok;
    } ctx_t;

    // saturate a 33-bit sum to 32 bits; returns {clipped, value}
    function automatic logic [32:0] sat33(input logic signed [32:0] s);
        logic [32:0] res;
        if (s[32] != s[31])
        begin
            res = s[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        end
        else
        begin
            res = {1'b0, s[31:0]};
        end
        return res;
    endfunction

    // drop fraction bits of a rounded product sum and saturate; returns {clipped, value}
    function automatic logic [32:0] sat_fin(input logic signed [65:0] w, input int fb);
        logic signed [65:0] t;
        logic [32:0]        res;
        t = w >>> fb;
        if (t > 66'sd2147483647)
        begin
            res = {1'b1, 32'h7FFF_FFFF};
        end
        else if (t < -66'sd2147483648)
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b0, t[31:0]};
        end
        return res;
    endfunction

endpackage

FILE: sv/v3a_arith.sv
// v3a_arith: three-stage multiply / sum / round-saturate front end of the vector ALU.
// Depends on v3a_pkg.
module v3a_arith
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [3:0]         func,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scalar,
    input  logic [30:0]        min_nsq,
    output logic               out_vld,
    output ctx_t               out_ctx,
    output logic [63:0]        out_sumsq
);

    localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);

    // stage 1: operand select and products
    logic signed [31:0] op_a [6];
    logic signed [31:0] op_b [6];
    logic signed [31:0] av   [3];
    logic signed [31:0] bv   [3];
    logic [32:0]        vres [3];
    logic signed [32:0] dsum [3];
    logic [32:0]        dabs [3];
    logic [2:0]         eq_ok;

    logic               vld1_reg;
    logic [3:0]         func1_reg;
    logic signed [63:0] prod_reg [6];
    logic [31:0]        vec1_reg [3];
    logic               vsat1_reg;
    logic               eq1_reg;
    logic [2:0]         neg1_reg;
    logic [31:0]        mag1_reg [3];

    assign av[0] = a_x;
    assign av[1] = a_y;
    assign av[2] = a_z;
    assign bv[0] = b_x;
    assign bv[1] = b_y;
    assign bv[2] = b_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            op_a[k]     = av[k];
            op_b[k]     = bv[k];
            op_a[k + 3] = 32'sd0;
            op_b[k + 3] = 32'sd0;
        end
        case (func)
            FN_SCALE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    op_b[k] = scalar;
                end
            end
            FN_NORM2, FN_NORM, FN_NRMLZ:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    op_b[k] = av[k];
                end
            end
            FN_CROSS:
            begin
                op_a[0] = a_y; op_b[0] = b_z;
                op_a[1] = a_z; op_b[1] = b_x;
                op_a[2] = a_x; op_b[2] = b_y;
                op_a[3] = a_z; op_b[3] = b_y;
                op_a[4] = a_x; op_b[4] = b_z;
                op_a[5] = a_y; op_b[5] = b_x;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dsum[k] = 33'(av[k]) - 33'(bv[k]);
            if (func == FN_SUB)
            begin
                vres[k] = sat33(dsum[k]);
            end
            else
            begin
                vres[k] = sat33(33'(av[k]) + 33'(bv[k]));
            end
            dabs[k]  = dsum[k][32] ? 33'(-dsum[k]) : 33'(dsum[k]);
            eq_ok[k] = !scalar[31] && (dabs[k] <= {1'b0, scalar});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        func1_reg <= func;
        for (int k = 0; k < 6; k++)
        begin
            prod_reg[k] <= 64'(op_a[k]) * 64'(op_b[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            vec1_reg[k] <= vres[k][31:0];
            neg1_reg[k] <= av[k][31];
            mag1_reg[k] <= av[k][31] ? 32'(-33'(av[k])) : av[k];
        end
        vsat1_reg <= vres[0][32] | vres[1][32] | vres[2][32];
        eq1_reg   <= &eq_ok;
    end

    // stage 2: sums with rounding constant
    logic               vld2_reg;
    logic [3:0]         func2_reg;
    logic signed [65:0] lane_reg [3];
    logic signed [65:0] dot_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        vec2_reg [3];
    logic               vsat2_reg;
    logic               eq2_reg;
    logic [2:0]         neg2_reg;
    logic [31:0]        mag2_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        func2_reg <= func1_reg;
        for (int k = 0; k < 3; k++)
        begin
            lane_reg[k] <= 66'(prod_reg[k]) - 66'(prod_reg[k + 3]) + RND;
            vec2_reg[k] <= vec1_reg[k];
            mag2_reg[k] <= mag1_reg[k];
        end
        dot_reg   <= 66'(prod_reg[0]) + 66'(prod_reg[1]) + 66'(prod_reg[2]) + RND;
        sq_reg    <= $unsigned(prod_reg[0]) + $unsigned(prod_reg[1]) + $unsigned(prod_reg[2]);
        vsat2_reg <= vsat1_reg;
        eq2_reg   <= eq1_reg;
        neg2_reg  <= neg1_reg;
    end

    // stage 3: round, saturate, select per opcode
    logic [32:0] fl [3];
    logic [32:0] fd;
    ctx_t        ctx_next;
    ctx_t        ctx_reg;
    logic        vld3_reg;
    logic [63:0] sumsq_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fl[k] = sat_fin(lane_reg[k], FRAC_BITS);
        end
        fd = sat_fin(dot_reg, FRAC_BITS);

        ctx_next         = '0;
        ctx_next.func    = func2_reg;
        ctx_next.neg     = neg2_reg;
        ctx_next.mag_x   = mag2_reg[0];
        ctx_next.mag_y   = mag2_reg[1];
        ctx_next.mag_z   = mag2_reg[2];
        ctx_next.norm_ok = (sq_reg != 64'd0) && (sq_reg >= (64'(min_nsq) << FRAC_BITS));
        case (func2_reg)
            FN_ADD, FN_SUB:
            begin
                ctx_next.rx  = vec2_reg[0];
                ctx_next.ry  = vec2_reg[1];
                ctx_next.rz  = vec2_reg[2];
                ctx_next.sat = vsat2_reg;
            end
            FN_SCALE, FN_CROSS:
            begin
                ctx_next.rx  = fl[0][31:0];
                ctx_next.ry  = fl[1][31:0];
                ctx_next.rz  = fl[2][31:0];
                ctx_next.sat = fl[0][32] | fl[1][32] | fl[2][32];
            end
            FN_DOT, FN_NORM2:
            begin
                ctx_next.rs  = fd[31:0];
                ctx_next.sat = fd[32];
            end
            FN_EQ:
            begin
                ctx_next.flag = eq2_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg   <= ctx_next;
        sumsq_reg <= sq_reg;
    end

    assign out_vld   = vld3_reg;
    assign out_ctx   = ctx_reg;
    assign out_sumsq = sumsq_reg;

endmodule

FILE: sv/v3a_sqrt.sv
// v3a_sqrt: pipelined digit-by-digit square root, one result bit per stage, then rounding.
// Depends on v3a_pkg.
module v3a_sqrt
    import v3a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic [63:0] in_rad,
    input  ctx_t        in_ctx,
    output logic        out_vld,
    output logic [32:0] out_root,
    output ctx_t        out_ctx
);

    logic        vld_reg  [SQRT_STEPS];
    logic [33:0] rem_reg  [SQRT_STEPS];
    logic [31:0] root_reg [SQRT_STEPS];
    logic [63:0] rad_reg  [SQRT_STEPS];
    ctx_t        ctx_reg  [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_step
        logic        vld_i;
        logic [33:0] rem_i;
        logic [31:0] root_i;
        logic [63:0] rad_i;
        ctx_t        ctx_i;
        logic [35:0] trial;
        logic [35:0] test;

        if (i == 0)
        begin : g_first
            assign vld_i  = in_vld;
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = in_rad;
            assign ctx_i  = in_ctx;
        end
        else
        begin : g_next
            assign vld_i  = vld_reg[i - 1];
            assign rem_i  = rem_reg[i - 1];
            assign root_i = root_reg[i - 1];
            assign rad_i  = rad_reg[i - 1];
            assign ctx_i  = ctx_reg[i - 1];
        end

        assign trial = {rem_i, rad_i[63:62]};
        assign test  = {2'b00, root_i, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (trial >= test)
            begin
                rem_reg[i]  <= 34'(trial - test);
                root_reg[i] <= {root_i[30:0], 1'b1};
            end
            else
            begin
                rem_reg[i]  <= trial[33:0];
                root_reg[i] <= {root_i[30:0], 1'b0};
            end
            rad_reg[i] <= {rad_i[61:0], 2'b00};
            ctx_reg[i] <= ctx_i;
        end
    end

    // round to nearest: bump when remainder exceeds the floor root
    logic        vld_out_reg;
    logic [32:0] root_out_reg;
    ctx_t        ctx_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out_reg <= 1'b0;
        end
        else
        begin
            vld_out_reg <= vld_reg[SQRT_STEPS - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        root_out_reg <= 33'(root_reg[SQRT_STEPS - 1])
                        + 33'(rem_reg[SQRT_STEPS - 1] > 34'(root_reg[SQRT_STEPS - 1]));
        ctx_out_reg  <= ctx_reg[SQRT_STEPS - 1];
    end

    assign out_vld  = vld_out_reg;
    assign out_root = root_out_reg;
    assign out_ctx  = ctx_out_reg;

endmodule

FILE: sv/v3a_div.sv
// v3a_div: three-lane pipelined restoring divider for normalize, one quotient bit per stage.
// Depends on v3a_pkg.
module v3a_div
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_vld,
    input  logic [32:0]                     in_root,
    input  ctx_t                            in_ctx,
    output logic                            out_vld,
    output logic [2:0][FRAC_BITS + 1:0]     out_quo,
    output ctx_t                            out_ctx
);

    // quotient stays below 2^(FRAC_BITS+1) since each |component| <= norm + 1/2
    localparam int QW = FRAC_BITS + 2;
    localparam int NW = 32 + FRAC_BITS + 1;

    // prep stage: rounded numerators |c| * 2^F + r/2
    logic                  vld0_reg;
    logic [2:0][NW - 1:0]  num_reg;
    logic [32:0]           root0_reg;
    ctx_t                  ctx0_reg;
    logic [2:0][31:0]      mag;

    assign mag[0] = in_ctx.mag_x;
    assign mag[1] = in_ctx.mag_y;
    assign mag[2] = in_ctx.mag_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_reg[k] <= NW'({mag[k], {FRAC_BITS{1'b0}}}) + NW'(in_root[32:1]);
        end
        root0_reg <= in_root;
        ctx0_reg  <= in_ctx;
    end

    logic                  vld_reg  [QW];
    logic [2:0][32:0]      part_reg [QW];
    logic [2:0][QW - 1:0]  nlo_reg  [QW];
    logic [2:0][QW - 1:0]  quo_reg  [QW];
    logic [32:0]           root_reg [QW];
    ctx_t                  ctx_reg  [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        logic                 vld_i;
        logic [2:0][32:0]     part_i;
        logic [2:0][QW - 1:0] nlo_i;
        logic [2:0][QW - 1:0] quo_i;
        logic [32:0]          root_i;
        ctx_t                 ctx_i;
        logic [2:0][33:0]     trial;

        if (i == 0)
        begin : g_first
            assign vld_i  = vld0_reg;
            assign root_i = root0_reg;
            assign ctx_i  = ctx0_reg;
            for (genvar k = 0; k < 3; k++)
            begin : g_lane
                assign part_i[k] = 33'(num_reg[k][NW - 1:QW]);
                assign nlo_i[k]  = num_reg[k][QW - 1:0];
                assign quo_i[k]  = '0;
            end
        end
        else
        begin : g_next
            assign vld_i  = vld_reg[i - 1];
            assign part_i = part_reg[i - 1];
            assign nlo_i  = nlo_reg[i - 1];
            assign quo_i  = quo_reg[i - 1];
            assign root_i = root_reg[i - 1];
            assign ctx_i  = ctx_reg[i - 1];
        end

        for (genvar k = 0; k < 3; k++)
        begin : g_trial
            assign trial[k] = {part_i[k], nlo_i[k][QW - 1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (trial[k] >= {1'b0, root_i})
                begin
                    part_reg[i][k] <= 33'(trial[k] - {1'b0, root_i});
                    quo_reg[i][k]  <= {quo_i[k][QW - 2:0], 1'b1};
                end
                else
                begin
                    part_reg[i][k] <= trial[k][32:0];
                    quo_reg[i][k]  <= {quo_i[k][QW - 2:0], 1'b0};
                end
                nlo_reg[i][k] <= {nlo_i[k][QW - 2:0], 1'b0};
            end
            root_reg[i] <= root_i;
            ctx_reg[i]  <= ctx_i;
        end
    end

    assign out_vld = vld_reg[QW - 1];
    assign out_quo = quo_reg[QW - 1];
    assign out_ctx = ctx_reg[QW - 1];

endmodule

FILE: sv/vector3_fixed_alu.sv
// vector3_fixed_alu: top level of the pipelined Q-format 3D vector ALU with APB config port.
// Depends on v3a_pkg, v3a_arith, v3a_sqrt, v3a_div.
//
//   channel   ports                                   transfer
//   -------   -------------------------------------   ------------------------------
//   command   start, busy, func, a_*, b_*, scalar     start && !busy at clk rise
//   result    done, r_x, r_y, r_z, r_scalar, flag,    done high for one cycle
//             saturated
//   config    psel, penable, pwrite, paddr, pwdata,   psel && penable && pwrite
//             prdata, pready
//
// One command per cycle; busy stays low. A command passes through the multiply/sum/round
// stages, the square root (one root bit per stage plus rounding), the normalize divider
// and the output register.
// Every opcode takes the same path, so results leave in command order.
// Reset clears the valid bits and sets min_norm_squared to 1.
module vector3_fixed_alu
    import v3a_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         func,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] scalar,
    output logic               done,
    output logic signed [31:0] r_x,
    output logic signed [31:0] r_y,
    output logic signed [31:0] r_z,
    output logic signed [31:0] r_scalar,
    output logic               flag,
    output logic               saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // config register
    logic [30:0] min_nsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_nsq_reg <= 31'd1;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_MIN_NORM_SQ))
        begin
            min_nsq_reg <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == REG_MIN_NORM_SQ) ? {1'b0, min_nsq_reg} : 32'd0;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    // datapath
    logic        ar_vld;
    ctx_t        ar_ctx;
    logic [63:0] ar_sumsq;

    v3a_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (start && !busy),
        .func      (func),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .scalar    (scalar),
        .min_nsq   (min_nsq_reg),
        .out_vld   (ar_vld),
        .out_ctx   (ar_ctx),
        .out_sumsq (ar_sumsq)
    );

    logic        sq_vld;
    logic [32:0] sq_root;
    ctx_t        sq_ctx;

    v3a_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (ar_vld),
        .in_rad   (ar_sumsq),
        .in_ctx   (ar_ctx),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_ctx  (sq_ctx)
    );

    // fold the norm result into the context before the divider
    ctx_t dv_in_ctx;

    always_comb
    begin
        dv_in_ctx = sq_ctx;
        if (sq_ctx.func == FN_NORM)
        begin
            if (sq_root[32] || sq_root[31])
            begin
                dv_in_ctx.rs  = 32'h7FFF_FFFF;
                dv_in_ctx.sat = 1'b1;
            end
            else
            begin
                dv_in_ctx.rs = sq_root[31:0];
            end
        end
    end

    logic                        dv_vld;
    logic [2:0][FRAC_BITS + 1:0] dv_quo;
    ctx_t                        dv_ctx;

    v3a_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (sq_vld),
        .in_root (sq_root),
        .in_ctx  (dv_in_ctx),
        .out_vld (dv_vld),
        .out_quo (dv_quo),
        .out_ctx (dv_ctx)
    );

    // output register
    logic        done_reg;
    logic [31:0] rx_reg;
    logic [31:0] ry_reg;
    logic [31:0] rz_reg;
    logic [31:0] rs_reg;
    logic        flag_reg;
    logic        sat_reg;
    logic [31:0] q32 [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            q32[k] = dv_ctx.neg[k] ? 32'(-33'(dv_quo[k])) : 32'(dv_quo[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg  <= dv_ctx.rs;
        sat_reg <= dv_ctx.sat;
        if ((dv_ctx.func == FN_NRMLZ) && dv_ctx.norm_ok)
        begin
            rx_reg   <= q32[0];
            ry_reg   <= q32[1];
            rz_reg   <= q32[2];
            flag_reg <= 1'b1;
        end
        else
        begin
            rx_reg   <= dv_ctx.rx;
            ry_reg   <= dv_ctx.ry;
            rz_reg   <= dv_ctx.rz;
            flag_reg <= dv_ctx.flag;
        end
    end

    assign done      = done_reg;
    assign r_x       = rx_reg;
    assign r_y       = ry_reg;
    assign r_z       = rz_reg;
    assign r_scalar  = rs_reg;
    assign flag      = flag_reg;
    assign saturated = sat_reg;

endmodule

FILE: bench/tb_vector3_fixed_alu.sv
// tb_vector3_fixed_alu: self-checking bench for the Q16.16 3D vector ALU.
// Depends on v3a_pkg and vector3_fixed_alu; a directed table, then random commands per
// min_norm_squared setting; results checked in order against typed rows or predictor.
module tb_vector3_fixed_alu
    import v3a_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB        = 16;
    localparam int LAT_WAIT  = 70;
    localparam int WD_LIMIT  = 3000;
    localparam int PHASE_LEN = 260;
    localparam logic [2:0] ADDR_MIN_NORM_SQ = 3'd0;
    localparam logic [2:0] ADDR_UNUSED      = 3'd4;
    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    typedef struct packed {
        logic [3:0]         fn;
        logic signed [31:0] ax, ay, az, bx, by, bz, s;
    } vcmd_t;

    typedef struct packed {
        logic signed [31:0] x, y, z, s;
        logic               flag, sat;
    } vres_t;

    typedef struct packed {
        vcmd_t c;
        logic  typed;
        vres_t e;
    } vrow_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [3:0] func = '0;
    logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [31:0] b_x = '0, b_y = '0, b_z = '0, scalar = '0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic busy, done, flag, saturated, pready;
    logic signed [31:0] r_x, r_y, r_z, r_scalar;
    logic [31:0] prdata;

    logic [30:0] min_norm_sq;
    vres_t       pending_q[$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    bit          gaps_on = 1'b1;

    vector3_fixed_alu dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic logic signed [31:0] clip(longint v, inout logic sat);
        if (v > longint'(QMAX))
        begin
            sat = 1'b1;
            return QMAX;
        end
        if (v < longint'(QMIN))
        begin
            sat = 1'b1;
            return QMIN;
        end
        return v[31:0];
    endfunction

    // round half up, drop FB fraction bits, saturate
    function automatic logic signed [31:0] round_clip(logic signed [127:0] w, inout logic sat);
        logic signed [127:0] t;
        t = (w + 128'sd32768) >>> FB;
        if (t > 128'sd2147483647)
        begin
            sat = 1'b1;
            return QMAX;
        end
        if (t < -128'sd2147483648)
        begin
            sat = 1'b1;
            return QMIN;
        end
        return t[31:0];
    endfunction

    function automatic longint unsigned sqrt_nearest(longint unsigned n);
        longint unsigned r, pw, x;
        r = 0;
        pw = 64'h4000_0000_0000_0000;
        x = n;
        while (pw > n)
            pw >>= 2;
        while (pw != 0)
        begin
            if (x >= r + pw)
            begin
                x -= r + pw;
                r = (r >> 1) + pw;
            end
            else
            begin
                r >>= 1;
            end
            pw >>= 2;
        end
        if (n - r * r > r)
            r++;
        return r;
    endfunction

    function automatic longint unsigned sum_sq(vcmd_t c);
        longint unsigned px, py, pz;
        px = longint'(c.ax) * longint'(c.ax);
        py = longint'(c.ay) * longint'(c.ay);
        pz = longint'(c.az) * longint'(c.az);
        return px + py + pz;
    endfunction

    function automatic vres_t predict_vec_op(vcmd_t c);
        vres_t r;
        logic st;
        longint unsigned n2, rt, m, q;
        longint dx, dy, dz, v;
        logic signed [127:0] w;
        logic signed [31:0] comp[3];
        r = '0;
        st = 1'b0;
        comp[0] = c.ax;
        comp[1] = c.ay;
        comp[2] = c.az;
        case (c.fn)
            FN_ADD:
            begin
                r.x = clip(longint'(c.ax) + longint'(c.bx), st);
                r.y = clip(longint'(c.ay) + longint'(c.by), st);
                r.z = clip(longint'(c.az) + longint'(c.bz), st);
            end
            FN_SUB:
            begin
                r.x = clip(longint'(c.ax) - longint'(c.bx), st);
                r.y = clip(longint'(c.ay) - longint'(c.by), st);
                r.z = clip(longint'(c.az) - longint'(c.bz), st);
            end
            FN_SCALE:
            begin
                w = longint'(c.ax) * longint'(c.s);
                r.x = round_clip(w, st);
                w = longint'(c.ay) * longint'(c.s);
                r.y = round_clip(w, st);
                w = longint'(c.az) * longint'(c.s);
                r.z = round_clip(w, st);
            end
            FN_DOT:
            begin
                w = 128'(longint'(c.ax) * longint'(c.bx)) + 128'(longint'(c.ay) * longint'(c.by))
                    + 128'(longint'(c.az) * longint'(c.bz));
                r.s = round_clip(w, st);
            end
            FN_CROSS:
            begin
                w = 128'(longint'(c.ay) * longint'(c.bz)) - 128'(longint'(c.az) * longint'(c.by));
                r.x = round_clip(w, st);
                w = 128'(longint'(c.az) * longint'(c.bx)) - 128'(longint'(c.ax) * longint'(c.bz));
                r.y = round_clip(w, st);
                w = 128'(longint'(c.ax) * longint'(c.by)) - 128'(longint'(c.ay) * longint'(c.bx));
                r.z = round_clip(w, st);
            end
            FN_NORM2:
            begin
                w = 128'(sum_sq(c));
                r.s = round_clip(w, st);
            end
            FN_NORM:
            begin
                rt = sqrt_nearest(sum_sq(c));
                if (rt > 64'h7FFF_FFFF)
                begin
                    st = 1'b1;
                    rt = 64'h7FFF_FFFF;
                end
                r.s = rt[31:0];
            end
            FN_NRMLZ:
            begin
                n2 = sum_sq(c);
                if (n2 != 0 && n2 >= (64'(min_norm_sq) << FB))
                begin
                    rt = sqrt_nearest(n2);
                    for (int i = 0; i < 3; i++)
                    begin
                        v = longint'(comp[i]);
                        m = $unsigned(v < 0 ? -v : v) << FB;
                        q = (m + rt / 2) / rt;
                        comp[i] = clip(v < 0 ? -longint'(q) : longint'(q), st);
                    end
                    r.x = comp[0];
                    r.y = comp[1];
                    r.z = comp[2];
                    r.flag = 1'b1;
                end
            end
            FN_EQ:
            begin
                dx = longint'(c.ax) - longint'(c.bx);
                dy = longint'(c.ay) - longint'(c.by);
                dz = longint'(c.az) - longint'(c.bz);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dz < 0) dz = -dz;
                r.flag = (dx <= longint'(c.s)) && (dy <= longint'(c.s)) && (dz <= longint'(c.s));
            end
            default:
            begin
            end
        endcase
        r.sat = st;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic vcmd_t mk(logic [3:0] fn, logic signed [31:0] ax, ay, az, bx, by, bz,
                                 s);
        vcmd_t c;
        c.fn = fn;
        c.ax = ax;
        c.ay = ay;
        c.az = az;
        c.bx = bx;
        c.by = by;
        c.bz = bz;
        c.s  = s;
        return c;
    endfunction

    function automatic vres_t res(logic signed [31:0] x, y, z, s, logic fl, sat);
        vres_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        r.s = s;
        r.flag = fl;
        r.sat = sat;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_comp();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: v = QMAX;
                    1: v = QMIN;
                    2: v = 0;
                    3: v = -1;
                    default: v = 1;
                endcase
            end
            1, 2, 3: v = $urandom_range(0, 32'h000F_FFFF);
            4, 5:    v = -$signed($urandom_range(0, 32'h00FF_FFFF));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic vcmd_t rand_cmd();
        vcmd_t c;
        c = mk($urandom_range(0, 19) == 0 ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8)),
               rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
               rand_comp());
        // mostly near-equal vectors for the tolerance compare
        if (c.fn == FN_EQ && $urandom_range(0, 2) != 0)
        begin
            c.s  = $urandom_range(0, 1023) - 16;
            c.bx = c.ax + $signed($urandom_range(0, 1200)) - 600;
            c.by = c.ay + $signed($urandom_range(0, 1200)) - 600;
            c.bz = c.az + $signed($urandom_range(0, 1200)) - 600;
        end
        return c;
    endfunction

    task automatic issue(vcmd_t c, logic typed, vres_t e);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        start  <= 1'b1;
        func   <= c.fn;
        a_x    <= c.ax;
        a_y    <= c.ay;
        a_z    <= c.az;
        b_x    <= c.bx;
        b_y    <= c.by;
        b_z    <= c.bz;
        scalar <= c.s;
        do
            @(posedge clk);
        while (busy);
        pending_q.push_back(typed ? e : predict_vec_op(c));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (LAT_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MIN_NORM_SQ)
            min_norm_sq = data[30:0];
    endtask

    // ---------------- result checker and watchdog ----------------
    always @(posedge clk)
    begin
        vres_t got, want;
        if (rst_n)
        begin
            stall_cycles++;
            if (start && !busy)
                stall_cycles = 0;
            if (done)
            begin
                stall_cycles = 0;
                got = res(r_x, r_y, r_z, r_scalar, flag, saturated);
                if (pending_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %p", got);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp x=%h y=%h z=%h s=%h f=%b sat=%b | got x=%h y=%h z=%h s=%h f=%b sat=%b",
                                     want.x, want.y, want.z, want.s, want.flag, want.sat,
                                     got.x, got.y, got.z, got.s, got.flag, got.sat);
                    end
                end
            end
            if (stall_cycles >= WD_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
                $display("** vector3_fixed_alu: FAILED **");
                $finish;
            end
        end
    end

    // ---------------- main sequence ----------------
    initial
    begin
        vrow_t rows[$];
        vres_t none;
        logic [31:0] settings[5];
        none = '0;
        min_norm_sq = 31'd1;
        settings[0] = 32'd0;
        settings[1] = 32'h7FFF_FFFF;
        settings[2] = 32'h0001_0000;
        settings[3] = $urandom_range(0, 32'h00FF_FFFF);
        settings[4] = $urandom & 32'h7FFF_FFFF;

        // typed rows: saturation, normalize floor and zero vector, unused codes, tolerance
        rows.push_back('{mk(FN_ADD, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0), 1'b1,
                         res(QMAX, QMAX, QMAX, 0, 1'b0, 1'b1)});
        rows.push_back('{mk(FN_SUB, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, 0), 1'b1,
                         res(QMIN, QMIN, QMIN, 0, 1'b0, 1'b1)});
        rows.push_back('{mk(FN_ADD, ONE, -ONE, 0, 2 * ONE, ONE, -1, 0), 1'b1,
                         res(3 * ONE, 0, -1, 0, 1'b0, 1'b0)});
        rows.push_back('{mk(FN_NRMLZ, 1, 0, 0, 0, 0, 0, 0), 1'b1, none});
        rows.push_back('{mk(FN_NRMLZ, 0, 0, 0, 5, 5, 5, 5), 1'b1, none});
        rows.push_back('{mk(4'd9, QMAX, QMIN, ONE, 1, 2, 3, 4), 1'b1, none});
        rows.push_back('{mk(4'd15, -1, -1, -1, -1, -1, -1, -1), 1'b1, none});
        rows.push_back('{mk(FN_EQ, ONE, ONE, ONE, ONE, ONE, ONE, -1), 1'b1, none});
        rows.push_back('{mk(FN_EQ, 7, 8, 9, 7, 8, 9, 0), 1'b1, res(0, 0, 0, 0, 1'b1, 1'b0)});
        // predicted rows
        rows.push_back('{mk(FN_SCALE, QMAX, QMIN, ONE, 0, 0, 0, QMAX), 1'b0, none});
        rows.push_back('{mk(FN_SCALE, QMIN, 1, -1, 0, 0, 0, QMIN), 1'b0, none});
        rows.push_back('{mk(FN_SCALE, 1, -1, 3, 0, 0, 0, 32'sh8000), 1'b0, none});
        rows.push_back('{mk(FN_DOT, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0), 1'b0, none});
        rows.push_back('{mk(FN_DOT, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, 0), 1'b0, none});
        rows.push_back('{mk(FN_DOT, 1, 0, 0, -32'sh8000, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_CROSS, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX, 0), 1'b0, none});
        rows.push_back('{mk(FN_NORM2, QMIN, QMIN, QMIN, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_NORM2, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_NORM, QMIN, QMIN, QMIN, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_NORM, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_NRMLZ, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_NRMLZ, QMIN, 0, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_NRMLZ, 256, 0, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(FN_EQ, QMIN, QMAX, 0, QMAX, QMIN, 0, QMAX), 1'b0, none});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            issue(rows[i].c, rows[i].typed, rows[i].e);
        repeat (PHASE_LEN) issue(rand_cmd(), 1'b0, none);

        // writes to an unmapped address must not change the floor
        drain();
        reg_write(ADDR_UNUSED, 32'h0000_0005);

        foreach (settings[k])
        begin
            drain();
            reg_write(ADDR_MIN_NORM_SQ, settings[k]);
            if (k == 4)
                gaps_on = 1'b0;
            repeat (PHASE_LEN) issue(rand_cmd(), 1'b0, none);
        end

        drain();
        if (mismatches == 0)
            $display("** vector3_fixed_alu: PASSED **");
        else
            $display("** vector3_fixed_alu: FAILED **");
        $finish;
    end

endmodule

FILE: vector3_fixed_alu.f
sv/v3a_pkg.sv
sv/v3a_arith.sv
sv/v3a_sqrt.sv
sv/v3a_div.sv
sv/vector3_fixed_alu.sv
bench/tb_vector3_fixed_alu.sv
